// File: src/multi_waveform_generator_top_macros.svh
// assertion macros for the waveform generator top level
// expects clk and rst_n in the scope of use
`ifndef MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH
`define MULTI_WAVEFORM_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define MWG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define MWG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mwg_pkg.sv
// shared constants, codes and sine table function for the waveform generator
// no dependencies
`timescale 1ns / 1ps

package mwg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int WAVE_W    = 2;
  localparam int STEP_W    = 32;
  localparam int AMP_W     = 15;
  localparam int COUNT_W   = 25;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ROM_W     = 16;
  localparam int MAG_IN_W  = 17;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_COSINE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd3;

  localparam logic [COUNT_W-1:0]  MAX_RUN  = 25'h1000000;
  localparam logic [MAG_IN_W-1:0] UNIT_MAG = 17'h08000;
  localparam logic [63:0]         PI_Q30   = 64'd3373259426;

  // entry k of the quarter-wave table: Q2.30 taylor series up to x^15,
  // rounded to Q1.15 and capped at one
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (PI_Q30 * 64'(k)) >> (abits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    v = ((unsigned'(sum) << 15) + (64'd1 << 29)) >> 30;
    if (v > 64'(UNIT_MAG)) begin
      v = 64'(UNIT_MAG);
    end
    return v[ROM_W-1:0];
  endfunction

endpackage

// File: src/mwg_in_if.sv
// request channel into the waveform generator: one tick with a restart flag
// no dependencies
`timescale 1ns / 1ps

interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// File: src/mwg_out_if.sv
// sample channel out of the waveform generator
// depends on mwg_pkg for the index width
`timescale 1ns / 1ps

interface mwg_out_if #(
  parameter int SAMPLE_BITS = mwg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [mwg_pkg::IDX_W-1:0]     sample_index;
  logic                          last;

  modport source (output valid, output sample, output sample_index, output last,
                  input ready);
  modport sink (input valid, input sample, input sample_index, input last,
                output ready);
endinterface

// File: src/multi_waveform_generator_top.sv
// a request accepted on the in channel passes through three register stages, counting the
// accepting edge, before its sample is valid on the out channel
// throughput: one sample per clock while out_if.ready holds; rom read, amplitude
// multiply and sign/clamp are each one register stage, all stalled stage by stage
// reset (rst_n low, synchronous): phase and sample index to zero, waveform sine,
// step and amplitude zero, run length one, pipeline empty
`timescale 1ns / 1ps
`include "multi_waveform_generator_top_macros.svh"

module multi_waveform_generator_top #(
  parameter int PHASE_BITS      = mwg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = mwg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = mwg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mwg_pkg::CFG_W-1:0]     cfg_data,
  mwg_in_if.sink                        in_if,
  mwg_out_if.source                     out_if
);

  localparam int TAB      = TABLE_ADDR_BITS;
  localparam int ADDR_LSB = PHASE_BITS - 2 - TAB;
  localparam int AMP_W    = mwg_pkg::AMP_W;
  localparam int IDX_W    = mwg_pkg::IDX_W;
  localparam int SAW_W    = PHASE_BITS + AMP_W + 1;
  localparam int SMAX     = (1 << (SAMPLE_BITS - 1)) - 1;

  localparam logic [PHASE_BITS-1:0]  HALF       = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [SAW_W-1:0]       SAW_RND    = SAW_W'(1) << (PHASE_BITS - 2);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                  unit;
    logic                  sin_neg;
    logic [PHASE_BITS-1:0] d;
    logic                  saw_neg;
    logic                  sq_neg;
    logic [IDX_W-1:0]      idx;
    logic                  last;
  } s1_t;

  typedef struct packed {
    logic [AMP_W-1:0] mag;
    logic             neg;
    logic [IDX_W-1:0] idx;
    logic             last;
  } s2_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]       idx;
    logic                   last;
  } out_t;

  // configuration
  logic [mwg_pkg::WAVE_W-1:0]  waveform_r;
  logic [mwg_pkg::STEP_W-1:0]  step_r;
  logic [AMP_W-1:0]            amp_r;
  logic [mwg_pkg::COUNT_W-1:0] count_r;
  logic [mwg_pkg::COUNT_W-1:0] count_nxt;

  // run state
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;

  // pipeline
  logic s1_v_r, s2_v_r, out_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  out_t out_r, out_nxt;
  logic ready_s1, ready_s2, ready_out;
  logic in_fire;

  // stage 0 signals
  logic [PHASE_BITS-1:0] phase_cur;
  logic [IDX_W-1:0]      cnt_cur;
  logic                  last_cur;
  logic [1:0]            quad;
  logic [TAB-1:0]        addr;
  logic [TAB-1:0]        rom_addr;
  logic [mwg_pkg::ROM_W-1:0] rom_q;

  // stage 1 signals
  logic [mwg_pkg::MAG_IN_W-1:0] m;
  logic [31:0]                  sin_prod;
  logic [32:0]                  sin_sum;
  logic [SAW_W-1:0]             saw_sum;
  logic [PHASE_BITS+AMP_W-1:0]  saw_prod;

  // stage 2 signals
  logic [SAMPLE_BITS-1:0] mag_c;

  assign ready_out = !out_v_r || out_if.ready;
  assign ready_s2  = !s2_v_r || ready_out;
  assign ready_s1  = !s1_v_r || ready_s2;
  assign in_if.ready = ready_s1;
  assign in_fire = in_if.valid && ready_s1;

  // configuration writes; run length is stored already saturated
  always_comb begin
    count_nxt = cfg_data[mwg_pkg::COUNT_W-1:0];
    if (count_nxt == '0) begin
      count_nxt = mwg_pkg::COUNT_W'(1);
    end else if (count_nxt > mwg_pkg::MAX_RUN) begin
      count_nxt = mwg_pkg::MAX_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r <= mwg_pkg::WAVE_SINE;
      step_r     <= '0;
      amp_r      <= '0;
      count_r    <= mwg_pkg::COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mwg_pkg::CFG_WAVEFORM:     waveform_r <= cfg_data[mwg_pkg::WAVE_W-1:0];
        mwg_pkg::CFG_PHASE_STEP:   step_r     <= cfg_data[mwg_pkg::STEP_W-1:0];
        mwg_pkg::CFG_AMPLITUDE:    amp_r      <= cfg_data[AMP_W-1:0];
        mwg_pkg::CFG_SAMPLE_COUNT: count_r    <= count_nxt;
        default: begin
        end
      endcase
    end
  end

  // stage 0: phase/index for this request, rom address, sawtooth distance
  always_comb begin
    phase_cur = in_if.restart ? '0 : phase_r;
    cnt_cur   = in_if.restart ? '0 : cnt_r;
    last_cur  = ({1'b0, cnt_cur} + mwg_pkg::COUNT_W'(1)) >= count_r;

    if (last_cur) begin
      phase_nxt = '0;
      cnt_nxt   = '0;
    end else begin
      phase_nxt = phase_cur + PHASE_BITS'(step_r);
      cnt_nxt   = cnt_cur + IDX_W'(1);
    end

    // cosine is the sine a quarter cycle ahead
    quad = phase_cur[PHASE_BITS-1 -: 2];
    if (waveform_r == mwg_pkg::WAVE_COSINE) begin
      quad = quad + 2'd1;
    end
    addr     = phase_cur[ADDR_LSB +: TAB];
    rom_addr = quad[0] ? TAB'(~addr + TAB'(1)) : addr;

    s1_nxt.unit    = quad[0] && (addr == '0);
    s1_nxt.sin_neg = quad[1];
    if (phase_cur <= HALF) begin
      s1_nxt.d       = HALF - phase_cur;
      s1_nxt.saw_neg = 1'b0;
    end else begin
      s1_nxt.d       = phase_cur - HALF;
      s1_nxt.saw_neg = 1'b1;
    end
    s1_nxt.sq_neg = phase_cur[PHASE_BITS-1];
    s1_nxt.idx    = cnt_cur;
    s1_nxt.last   = last_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  mwg_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // stage 1: amplitude scaling
  always_comb begin
    m        = s1_r.unit ? mwg_pkg::UNIT_MAG : {1'b0, rom_q};
    sin_prod = amp_r * m;
    sin_sum  = {1'b0, sin_prod} + 33'd16384;
    saw_prod = amp_r * s1_r.d;
    saw_sum  = {1'b0, saw_prod} + SAW_RND;

    s2_nxt.idx  = s1_r.idx;
    s2_nxt.last = s1_r.last;
    case (waveform_r)
      mwg_pkg::WAVE_SINE, mwg_pkg::WAVE_COSINE: begin
        s2_nxt.mag = sin_sum[15 +: AMP_W];
        s2_nxt.neg = s1_r.sin_neg;
      end
      mwg_pkg::WAVE_SQUARE: begin
        s2_nxt.mag = amp_r;
        s2_nxt.neg = s1_r.sq_neg;
      end
      default: begin
        s2_nxt.mag = saw_sum[PHASE_BITS-1 +: AMP_W];
        s2_nxt.neg = s1_r.saw_neg;
      end
    endcase
  end

  // stage 2: clamp to the symmetric range and apply the sign
  always_comb begin
    if (32'(s2_r.mag) > 32'(SMAX)) begin
      mag_c = SAMPLE_BITS'(SMAX);
    end else begin
      mag_c = SAMPLE_BITS'(s2_r.mag);
    end
    out_nxt.sample = s2_r.neg ? (~mag_c + SAMPLE_BITS'(1)) : mag_c;
    out_nxt.idx    = s2_r.idx;
    out_nxt.last   = s2_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ready_s1) begin
        s1_v_r <= in_fire;
      end
      if (ready_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (ready_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (ready_s2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
    if (ready_out && s2_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.sample       = signed'(out_r.sample);
  assign out_if.sample_index = out_r.idx;
  assign out_if.last         = out_r.last;

  `MWG_ASSERT_NEXT(a_last_rewinds, in_fire && last_cur, phase_r == '0 && cnt_r == '0, "run state not cleared after last sample")
  `MWG_ASSERT_NOW(a_no_min_sample, out_v_r, out_r.sample != SAMPLE_MIN, "sample outside symmetric range")
  `MWG_ASSERT_NEXT(a_s2_held, s2_v_r && !ready_out, s2_v_r && $stable(s2_r), "stalled multiply stage lost its request")
  `MWG_ASSERT_NEXT(a_s1_held, s1_v_r && !ready_s2, s1_v_r && $stable(s1_r) && $stable(rom_q), "stalled rom stage lost its request")

endmodule

// File: src/mwg_sine_rom.sv
// quarter-wave sine rom with registered read
// depends on mwg_pkg for the table function
`timescale 1ns / 1ps

module mwg_sine_rom #(
  parameter int ADDR_BITS = mwg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ADDR_BITS-1:0]      rd_addr,
  output logic [mwg_pkg::ROM_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [mwg_pkg::ROM_W-1:0] rom_w [DEPTH];
  logic [mwg_pkg::ROM_W-1:0] rd_data_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom_w[k] = mwg_pkg::sine_entry(k, ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_w[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
